### rtl/tlpi_pkg.sv
`timescale 1ns / 1ps

package tlpi_pkg;

   // Internal widths of positions and timestamps.
   localparam int POS_WIDTH  = 32;
   localparam int TIME_WIDTH = 32;

   // Width of the bit counter of the serial multiply-divide.
   localparam int CNT_W = $clog2(POS_WIDTH);

   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = $clog2(NUM_AXES);

   // Request action codes.
   localparam logic ACT_TARGET = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef logic signed [POS_WIDTH-1:0] pos_type;
   typedef logic signed [POS_WIDTH:0]   diff_type;
   typedef logic [POS_WIDTH-1:0]        mag_type;
   typedef logic [TIME_WIDTH-1:0]       time_type;
   typedef logic [TIME_WIDTH:0]         time_ext_type;

endpackage

### rtl/timed_linear_position_interpolator.sv
`timescale 1ns / 1ps
// A target request is absorbed in its accept cycle and gives no response. A query
// that snaps to the goal goes to DONE, through CHECK unless the goal was already
// reached; an interpolating query runs the three axes in turn through one shared
// divide step unit, each magnitude bit in a doubling and an adding phase. Requests are
// taken one at a time; req_ready is high only while the sequencer idles. Reset (synchronous,
// active high) zeroes start, goal, output positions, last time, interval; sets reached.

module timed_linear_position_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_now_us,
   input  logic [31:0] req_target_x,
   input  logic [31:0] req_target_y,
   input  logic [31:0] req_target_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_pos_z,
   output logic        rsp_reached
);

   import tlpi_pkg::*;

   // Sequencer states. IDLE takes requests, CHECK decides between snapping and
   // interpolating, LOAD/ABS set up one axis, STEP runs the serial multiply-divide,
   // FINISH applies the increment, and DONE hands the result to the output register.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD,
      ST_ABS,
      ST_STEP,
      ST_FINISH,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Architectural state of the interpolator.
   time_type last_time_ff, last_time_in;
   time_type interval_ff, interval_in;
   pos_type  start_ff [NUM_AXES];
   pos_type  start_in [NUM_AXES];
   pos_type  goal_ff [NUM_AXES];
   pos_type  goal_in [NUM_AXES];
   pos_type  outpos_ff [NUM_AXES];
   pos_type  outpos_in [NUM_AXES];
   logic     reached_ff, reached_in;

   // Working registers of the shared divide step unit.
   time_type            elapsed_ff, elapsed_in;
   logic [AXIS_W-1:0]   axis_ff, axis_in;
   diff_type            diff_ff, diff_in;
   logic                neg_ff, neg_in;
   mag_type             mag_ff, mag_in;
   mag_type             quo_ff, quo_in;
   time_type            rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                phase_ff, phase_in;

   // Output register; it lets the sequencer move on while a response waits.
   logic     rsp_valid_ff, rsp_valid_in;
   pos_type  rsp_pos_ff [NUM_AXES];
   pos_type  rsp_pos_in [NUM_AXES];
   logic     rsp_reached_ff, rsp_reached_in;

   // Shared adder and compare-subtract of the divide step.
   time_ext_type add_a;
   time_ext_type add_b;
   time_ext_type sum;
   time_ext_type sum_sub;
   logic         sum_ge;
   mag_type      quo_base;

   logic     req_fire;
   time_type now;
   pos_type  req_tgt [NUM_AXES];
   logic     same_pos;
   pos_type  new_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign now       = TIME_WIDTH'(req_now_us);

   // The 32-bit targets are sign extended, then wrapped to the internal width.
   assign req_tgt[0] = POS_WIDTH'($signed(req_target_x));
   assign req_tgt[1] = POS_WIDTH'($signed(req_target_y));
   assign req_tgt[2] = POS_WIDTH'($signed(req_target_z));

   assign same_pos = (goal_ff[0] == start_ff[0]) && (goal_ff[1] == start_ff[1]) &&
                     (goal_ff[2] == start_ff[2]);

   // In the first phase of a bit the remainder doubles; in the second the
   // elapsed time is added when the current magnitude bit is set. Each phase
   // ends with a conditional subtract of the interval, which bumps the quotient.
   assign add_a    = phase_ff ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign add_b    = (phase_ff && mag_ff[POS_WIDTH-1]) ? {1'b0, elapsed_ff} : '0;
   assign sum      = add_a + add_b;
   assign sum_ge   = (sum >= {1'b0, interval_ff});
   assign sum_sub  = sum - {1'b0, interval_ff};
   assign quo_base = phase_ff ? quo_ff : {quo_ff[POS_WIDTH-2:0], 1'b0};

   // The increment is truncated toward zero, then applied with the sign of the move.
   assign new_pos = neg_ff ? (start_ff[axis_ff] - pos_type'(quo_ff))
                           : (start_ff[axis_ff] + pos_type'(quo_ff));

   always_comb begin
      state_in       = state_ff;
      last_time_in   = last_time_ff;
      interval_in    = interval_ff;
      start_in       = start_ff;
      goal_in        = goal_ff;
      outpos_in      = outpos_ff;
      reached_in     = reached_ff;
      elapsed_in     = elapsed_ff;
      axis_in        = axis_ff;
      diff_in        = diff_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      phase_in       = phase_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pos_in     = rsp_pos_ff;
      rsp_reached_in = rsp_reached_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_TARGET) begin
                  // A new target starts a move from the last answered position.
                  interval_in  = now - last_time_ff;
                  last_time_in = now;
                  start_in     = outpos_ff;
                  goal_in      = req_tgt;
                  reached_in   = 1'b0;
               end else if (reached_ff) begin
                  outpos_in = goal_ff;
                  state_in  = ST_DONE;
               end else begin
                  elapsed_in = now - last_time_ff;
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // A run-out interval, a zero interval or a zero distance snaps to the goal.
            if ((elapsed_ff >= interval_ff) || same_pos) begin
               reached_in = 1'b1;
               outpos_in  = goal_ff;
               state_in   = ST_DONE;
            end else begin
               axis_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            diff_in  = {goal_ff[axis_ff][POS_WIDTH-1], goal_ff[axis_ff]} -
                       {start_ff[axis_ff][POS_WIDTH-1], start_ff[axis_ff]};
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = diff_ff[POS_WIDTH];
            mag_in   = diff_ff[POS_WIDTH] ? POS_WIDTH'(-diff_ff) : diff_ff[POS_WIDTH-1:0];
            quo_in   = '0;
            rem_in   = '0;
            cnt_in   = CNT_W'(POS_WIDTH - 1);
            phase_in = 1'b0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            rem_in   = sum_ge ? sum_sub[TIME_WIDTH-1:0] : sum[TIME_WIDTH-1:0];
            quo_in   = quo_base + POS_WIDTH'(sum_ge);
            phase_in = !phase_ff;
            if (phase_ff) begin
               mag_in = {mag_ff[POS_WIDTH-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            outpos_in[axis_ff] = new_pos;
            if (axis_ff == AXIS_W'(NUM_AXES - 1)) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            // Wait until the output register is free, then load it.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pos_in     = outpos_ff;
               rsp_reached_in = reached_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_time_ff <= '0;
         interval_ff  <= '0;
         start_ff     <= '{default: '0};
         goal_ff      <= '{default: '0};
         outpos_ff    <= '{default: '0};
         reached_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_time_ff <= last_time_in;
         interval_ff  <= interval_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         outpos_ff    <= outpos_in;
         reached_ff   <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
      end
      elapsed_ff     <= elapsed_in;
      diff_ff        <= diff_in;
      neg_ff         <= neg_in;
      mag_ff         <= mag_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_reached_ff <= rsp_reached_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = 32'(rsp_pos_ff[0]);
   assign rsp_pos_y   = 32'(rsp_pos_ff[1]);
   assign rsp_pos_z   = 32'(rsp_pos_ff[2]);
   assign rsp_reached = rsp_reached_ff;

`ifndef NO_ASSERTIONS
   // Interpolation only runs while the move is still under way.
   a_step_in_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (elapsed_ff < interval_ff))
      else $error("divide step running with elapsed time not below interval");

   // The partial remainder always stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (rem_ff < interval_ff))
      else $error("divide remainder out of range");

   // A new target always clears the reached flag.
   a_target_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_action == ACT_TARGET)) |=> !reached_ff)
      else $error("reached flag not cleared by a new target");

   // A response that is not reached can only come out of the interpolation path.
   a_interp_resp: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !rsp_reached_ff) |-> ($past(axis_ff) == AXIS_W'(NUM_AXES - 1)))
      else $error("interpolated response without all axes done");
`endif

endmodule

### tb/tlpi_position_checker.sv
`timescale 1ns / 1ps

module tlpi_position_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_now_us,
   input  logic [31:0] req_target_x,
   input  logic [31:0] req_target_y,
   input  logic [31:0] req_target_z,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pos_x,
   input  logic [31:0] rsp_pos_y,
   input  logic [31:0] rsp_pos_z,
   input  logic        rsp_reached,
   output int          outstanding,
   output int          mismatches,
   output int          answers,
   output int          glides
);

   import tlpi_pkg::*;

   typedef struct packed {
      pos_type x;
      pos_type y;
      pos_type z;
      logic    reached;
   } answer_type;

   answer_type  answers_due [$];

   time_type last_target_at;
   time_type move_span;
   pos_type  seg_start   [NUM_AXES];
   pos_type  seg_goal    [NUM_AXES];
   pos_type  last_answer [NUM_AXES];
   logic     at_goal;

   int n_mismatch = 0;
   int n_answered = 0;
   int n_glide    = 0;

   // Partial move along one axis: the increment is truncated toward zero before
   // its sign is applied, so the point always stays between start and goal.
   function automatic pos_type glide_axis(input pos_type from, input pos_type to,
                                          input time_type elapsed, input time_type span);
      diff_type                            d;
      logic [POS_WIDTH:0]                  mag;
      logic [POS_WIDTH+TIME_WIDTH:0]       prod;
      logic [POS_WIDTH+TIME_WIDTH:0]       q;
      d    = diff_type'(to) - diff_type'(from);
      mag  = d[POS_WIDTH] ? -d : d;
      prod = mag * elapsed;
      q    = prod / span;
      return d[POS_WIDTH] ? from - pos_type'(q[POS_WIDTH-1:0])
                          : from + pos_type'(q[POS_WIDTH-1:0]);
   endfunction

   function automatic void take_target(input time_type now, input pos_type x,
                                       input pos_type y, input pos_type z);
      move_span      = now - last_target_at;
      last_target_at = now;
      seg_start      = last_answer;
      seg_goal[0]    = x;
      seg_goal[1]    = y;
      seg_goal[2]    = z;
      at_goal        = 1'b0;
   endfunction

   function automatic answer_type answer_query(input time_type now);
      time_type    elapsed;
      logic        same;
      answer_type  ans;
      elapsed = now - last_target_at;
      if (!at_goal) begin
         same = 1'b1;
         for (int a = 0; a < NUM_AXES; a++)
            if (seg_goal[a] != seg_start[a]) same = 1'b0;
         if (elapsed >= move_span || same) begin
            at_goal     = 1'b1;
            last_answer = seg_goal;
         end else begin
            n_glide++;
            for (int a = 0; a < NUM_AXES; a++)
               last_answer[a] = glide_axis(seg_start[a], seg_goal[a], elapsed, move_span);
         end
      end else begin
         last_answer = seg_goal;
      end
      ans.x       = last_answer[0];
      ans.y       = last_answer[1];
      ans.z       = last_answer[2];
      ans.reached = at_goal;
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      answer_type due;
      answer_type got;
      if (reset) begin
         answers_due.delete();
         last_target_at = '0;
         move_span      = '0;
         at_goal        = 1'b1;
         for (int a = 0; a < NUM_AXES; a++) begin
            seg_start[a]   = '0;
            seg_goal[a]    = '0;
            last_answer[a] = '0;
         end
      end else begin
         // The response side goes first; it always belongs to an earlier query.
         if (rsp_valid && rsp_ready) begin
            got = {pos_type'(rsp_pos_x), pos_type'(rsp_pos_y), pos_type'(rsp_pos_z),
                   rsp_reached};
            if (answers_due.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("%0t: answer with no query pending: x=%h y=%h z=%h reached=%b",
                           $realtime, got.x, got.y, got.z, got.reached);
            end else begin
               due = answers_due.pop_front();
               n_answered++;
               if (got.x !== due.x || got.y !== due.y || got.z !== due.z ||
                   got.reached !== due.reached) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display({"%0t: answer mismatch: expected x=%h y=%h z=%h reached=%b,",
                               " got x=%h y=%h z=%h reached=%b"},
                              $realtime, due.x, due.y, due.z, due.reached,
                              got.x, got.y, got.z, got.reached);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_action == ACT_TARGET)
               take_target(TIME_WIDTH'(req_now_us), pos_type'($signed(req_target_x)),
                           pos_type'($signed(req_target_y)),
                           pos_type'($signed(req_target_z)));
            else
               answers_due.push_back(answer_query(TIME_WIDTH'(req_now_us)));
         end
      end
      outstanding <= answers_due.size();
      mismatches  <= n_mismatch;
      answers     <= n_answered;
      glides      <= n_glide;
   end

endmodule

### tb/timed_linear_position_interpolator_tb.sv
`timescale 1ns / 1ps

module timed_linear_position_interpolator_tb;
   import tlpi_pkg::*;

   localparam int RANDOM_ITEMS  = 900;
   // The limit leaves room for the slowest clean run, counting interpolating queries, the
   // worst sender gap and the longest response stall.
   localparam int CYCLE_LIMIT   = 1_000_000;
   // Quiet time after the last answer, long enough to cover one full interpolation.
   localparam int SETTLE_CYCLES = 300;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_action   = ACT_TARGET;
   logic [31:0] req_now_us   = '0;
   logic [31:0] req_target_x = '0;
   logic [31:0] req_target_y = '0;
   logic [31:0] req_target_z = '0;
   logic        rsp_ready    = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [31:0] rsp_pos_x;
   logic [31:0] rsp_pos_y;
   logic [31:0] rsp_pos_z;
   logic        rsp_reached;

   int outstanding;
   int mismatches;
   int answers;
   int glides;

   timed_linear_position_interpolator dut (.*);

   tlpi_position_checker checker_inst (.*);

   always #6 clock = ~clock;

   // Watchdog: a hung handshake or a lost answer ends the run here.
   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d answers outstanding.", cycles, outstanding);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response back-pressure. The receiver switches at random between four behaviors:
   // always ready, mostly ready, mostly stalled, and a slow square wave on a tick counter
   // bit that holds ready low and high in turn.
   int         stall_mode = 0;
   int         mode_left  = 0;
   logic [4:0] tick       = '0;
   always @(posedge clock) begin
      tick <= tick + 1'b1;
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(64, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= tick[4];
      endcase
   end

   // Stimulus-side bookkeeping. The generator keeps its own idea of when the last
   // target arrived, so that it can place queries inside the move it just started.
   logic [31:0] tgt_time  = '0;
   logic [31:0] goal_x    = '0;
   logic [31:0] goal_y    = '0;
   logic [31:0] goal_z    = '0;
   logic        settled   = 1'b1;
   int          burst_left = 0;
   int          sent       = 0;
   int          n_targets  = 0;
   int          n_queries  = 0;

   // Present one request, hold it until the block takes it, then apply the sender's
   // burst pacing. Valid is only lowered when a gap actually follows, so back-to-back
   // requests keep valid high across the handshake.
   task automatic send_req(input logic act, input logic [31:0] now,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
      int gap;
      req_valid    <= 1'b1;
      req_action   <= act;
      req_now_us   <= now;
      req_target_x <= x;
      req_target_y <= y;
      req_target_z <= z;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (act == ACT_TARGET) begin
         n_targets++;
         tgt_time = now;
         goal_x   = x;
         goal_y   = y;
         goal_z   = z;
         settled  = 1'b0;
      end else begin
         n_queries++;
      end
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         // A long stretch with no idle cycles at all.
         burst_left = $urandom_range(30, 80);
      end else begin
         burst_left = $urandom_range(0, 12);
         gap        = $urandom_range(1, 25);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending until every query has been answered. The checker's count is
   // registered, so the loop waits on the clock before it first trusts the count.
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [31:0] rand_coord(input logic [31:0] near);
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return 32'($urandom_range(0, 8000)) - 32'd4000;
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return near + 32'($urandom_range(0, 1024)) - 32'd512;
      endcase
   endfunction

   // One well-formed move: a target whose interval is the time since the previous
   // target, followed by queries placed mostly inside that interval. Some moves end
   // with a query past the due time so that the goal is reached.
   task automatic move_sequence;
      logic [31:0] gap;
      logic [31:0] off;
      logic [31:0] x, y, z;
      int          nq;
      case ($urandom_range(0, 7))
         0:       gap = $urandom_range(1, 16);
         1, 2:    gap = $urandom_range(17, 5000);
         3, 4:    gap = $urandom_range(5001, 2_000_000);
         5, 6:    gap = $urandom;
         default: gap = '0;
      endcase
      if (settled && $urandom_range(0, 5) == 0) begin
         // The goal already stands at the last answer, so the move has no length.
         x = goal_x;
         y = goal_y;
         z = goal_z;
      end else begin
         x = rand_coord(goal_x);
         y = rand_coord(goal_y);
         z = rand_coord(goal_z);
      end
      send_req(ACT_TARGET, tgt_time + gap, x, y, z);
      nq = $urandom_range(0, 5);
      for (int k = 0; k < nq; k++) begin
         if (gap != 0 && (k < nq - 1 || $urandom_range(0, 2) != 0))
            off = $urandom_range(0, gap - 1);
         else
            off = gap + 32'($urandom_range(0, 100));
         send_req(ACT_QUERY, tgt_time + off, $urandom, $urandom, $urandom);
         if (off >= gap) settled = 1'b1;
      end
   endtask

   // Unstructured requests: random action, random time, random coordinates.
   task automatic noise_sequence;
      int n;
      n = $urandom_range(1, 4);
      repeat (n)
         send_req(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin : stimulus
      int  directed;
      bit  paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A query before any target answers the reset goal, the origin, as reached.
      send_req(ACT_QUERY, 32'd5, 32'hdead_beef, 32'h1234_5678, 32'h8765_4321);
      // First move from the origin to the corners of the range over 100 us.
      send_req(ACT_TARGET, 32'd100, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
      send_req(ACT_QUERY, 32'd100, '0, '0, '0);
      send_req(ACT_QUERY, 32'd150, '1, '1, '1);
      send_req(ACT_QUERY, 32'd199, '0, '0, '0);
      send_req(ACT_QUERY, 32'd200, '0, '0, '0);
      // Once reached, even a time far in the past answers the goal.
      send_req(ACT_QUERY, 32'd50, '0, '0, '0);
      // Full-range reversal: the x distance is the widest the fields allow.
      send_req(ACT_TARGET, 32'd200, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      send_req(ACT_QUERY, 32'd201, '0, '0, '0);
      send_req(ACT_QUERY, 32'd299, '0, '0, '0);
      // New target mid-move: the start point is the last answered position.
      send_req(ACT_TARGET, 32'd299, 32'd1, 32'd2, 32'd3);
      // Two targets at the same time give a zero interval.
      send_req(ACT_TARGET, 32'd299, 32'd5, 32'd5, 32'd5);
      send_req(ACT_QUERY, 32'd299, '0, '0, '0);
      // Same goal again: a move of zero distance snaps at once.
      send_req(ACT_TARGET, 32'd400, 32'd5, 32'd5, 32'd5);
      send_req(ACT_QUERY, 32'd401, '0, '0, '0);
      // A very long interval, with queries across the wrap of the time counter.
      send_req(ACT_TARGET, 32'hffff_fff0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
      send_req(ACT_QUERY, 32'h0000_0020, '0, '0, '0);
      send_req(ACT_QUERY, 32'h7fff_ffff, '0, '0, '0);
      // A target just after the wrap: the interval counts forward across it.
      send_req(ACT_TARGET, 32'h0000_0010, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ff00);
      send_req(ACT_QUERY, 32'h0000_0020, '0, '0, '0);
      send_req(ACT_QUERY, 32'h0000_0030, '0, '0, '0);
      directed = sent;
      drain();

      while (sent < directed + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 8)
            move_sequence();
         else
            noise_sequence();
         // Halfway through, let the block run completely dry once.
         if (!paused && sent >= directed + RANDOM_ITEMS / 2) begin
            drain();
            paused = 1'b1;
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d targets, %0d queries); %0d answers checked, %0d of them mid-move.",
               sent, n_targets, n_queries, answers, glides);
      $display("Mismatches: %0d, answers still outstanding: %0d.", mismatches, outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/tlpi_pkg.sv
rtl/timed_linear_position_interpolator.sv
tb/tlpi_position_checker.sv
tb/timed_linear_position_interpolator_tb.sv
